@@ design/ppe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppe_pkg: shared types, constants and microcode for the peak prominence engine
// Holds the datapath control and status bundles and the sequencer program.
// ----------------------------------------------------------------------------
package ppe_pkg;

	localparam int SAMPLE_W        = 32;
	localparam int IDX_W           = 7;
	localparam int PPE_MAX_SAMPLES = 128;
	localparam int RESULT_CAP      = 64;
	localparam int RES_CNT_W       = $clog2(RESULT_CAP + 1);
	localparam logic signed [SAMPLE_W-1:0] THR_RESET = {1'b1, {(SAMPLE_W-1){1'b0}}};

	localparam int STEP_W = 5;
	typedef logic [STEP_W-1:0] step_t;

	// program step addresses
	localparam step_t ST_IDLE    = 5'd0;
	localparam step_t ST_CHK     = 5'd1;
	localparam step_t ST_RB      = 5'd2;
	localparam step_t ST_RC      = 5'd3;
	localparam step_t ST_TEST    = 5'd4;
	localparam step_t ST_LW_RD   = 5'd5;
	localparam step_t ST_LW_TST  = 5'd6;
	localparam step_t ST_LM_NXT  = 5'd7;
	localparam step_t ST_LM_RD   = 5'd8;
	localparam step_t ST_LM_MIN  = 5'd9;
	localparam step_t ST_RW_INIT = 5'd10;
	localparam step_t ST_RW_CHK  = 5'd11;
	localparam step_t ST_RW_TST  = 5'd12;
	localparam step_t ST_PK      = 5'd13;
	localparam step_t ST_PUSH    = 5'd14;
	localparam step_t ST_CAP     = 5'd15;
	localparam step_t ST_NEXT    = 5'd16;
	localparam step_t ST_FIN     = 5'd17;
	localparam step_t ST_DONE    = 5'd18;

	typedef enum logic [1:0] {
		A_IM1,
		A_I,
		A_IP1,
		A_J
	} addr_sel_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_LATCH_A,
		OP_LATCH_B,
		OP_JINIT_L,
		OP_LWALK,
		OP_JINC,
		OP_LMIN,
		OP_RINIT,
		OP_RSTEP,
		OP_REF,
		OP_PUSH,
		OP_NEXT,
		OP_FIN
	} op_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NOT_START,
		C_I_END,
		C_NOT_PEAK,
		C_LW_MORE,
		C_J1_EQ_I,
		C_J_END,
		C_RW_MORE,
		C_PUSH_WAIT,
		C_OUT_BUSY,
		C_CAP
	} cond_t;

	typedef struct packed {
		addr_sel_t addr_sel;
		op_t       op;
		cond_t     cond;
		step_t     target;
	} ucode_t;

	typedef struct packed {
		addr_sel_t addr_sel;
		op_t       op;
		logic      jump;
	} ctrl_t;

	typedef struct packed {
		logic not_start;
		logic i_end;
		logic not_peak;
		logic lw_more;
		logic j1_eq_i;
		logic j_end;
		logic rw_more;
		logic push_wait;
		logic out_busy;
		logic cap;
	} status_t;

	// control store: jump to target when cond holds, else fall through
	function automatic ucode_t ucode(input step_t step);
		ucode_t cw;
		cw = '{addr_sel: A_J, op: OP_NOP, cond: C_ALWAYS, target: ST_IDLE};
		unique case (step)
			ST_IDLE:    cw = '{addr_sel: A_J,   op: OP_LOAD,    cond: C_NOT_START, target: ST_IDLE};
			ST_CHK:     cw = '{addr_sel: A_IM1, op: OP_NOP,     cond: C_I_END,     target: ST_FIN};
			ST_RB:      cw = '{addr_sel: A_I,   op: OP_LATCH_A, cond: C_NEVER,     target: ST_IDLE};
			ST_RC:      cw = '{addr_sel: A_IP1, op: OP_LATCH_B, cond: C_NEVER,     target: ST_IDLE};
			ST_TEST:    cw = '{addr_sel: A_J,   op: OP_JINIT_L, cond: C_NOT_PEAK,  target: ST_NEXT};
			ST_LW_RD:   cw = '{addr_sel: A_J,   op: OP_NOP,     cond: C_NEVER,     target: ST_IDLE};
			ST_LW_TST:  cw = '{addr_sel: A_J,   op: OP_LWALK,   cond: C_LW_MORE,   target: ST_LW_RD};
			ST_LM_NXT:  cw = '{addr_sel: A_J,   op: OP_JINC,    cond: C_J1_EQ_I,   target: ST_RW_INIT};
			ST_LM_RD:   cw = '{addr_sel: A_J,   op: OP_NOP,     cond: C_NEVER,     target: ST_IDLE};
			ST_LM_MIN:  cw = '{addr_sel: A_J,   op: OP_LMIN,    cond: C_ALWAYS,    target: ST_LM_NXT};
			ST_RW_INIT: cw = '{addr_sel: A_J,   op: OP_RINIT,   cond: C_NEVER,     target: ST_IDLE};
			ST_RW_CHK:  cw = '{addr_sel: A_J,   op: OP_NOP,     cond: C_J_END,     target: ST_PK};
			ST_RW_TST:  cw = '{addr_sel: A_J,   op: OP_RSTEP,   cond: C_RW_MORE,   target: ST_RW_CHK};
			ST_PK:      cw = '{addr_sel: A_J,   op: OP_REF,     cond: C_NEVER,     target: ST_IDLE};
			ST_PUSH:    cw = '{addr_sel: A_J,   op: OP_PUSH,    cond: C_PUSH_WAIT, target: ST_PUSH};
			ST_CAP:     cw = '{addr_sel: A_J,   op: OP_NOP,     cond: C_CAP,       target: ST_FIN};
			ST_NEXT:    cw = '{addr_sel: A_J,   op: OP_NEXT,    cond: C_ALWAYS,    target: ST_CHK};
			ST_FIN:     cw = '{addr_sel: A_J,   op: OP_FIN,     cond: C_OUT_BUSY,  target: ST_FIN};
			ST_DONE:    cw = '{addr_sel: A_J,   op: OP_NOP,     cond: C_ALWAYS,    target: ST_IDLE};
			default:    cw = '{addr_sel: A_J,   op: OP_NOP,     cond: C_ALWAYS,    target: ST_IDLE};
		endcase
		return cw;
	endfunction

endpackage

@@ design/ppe_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppe_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ppe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ design/ppe_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppe_seq: microcode sequencer
// Step counter over the control store with conditional jumps on datapath flags.
// ----------------------------------------------------------------------------
module ppe_seq
	import ppe_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  status_t status,
	output ctrl_t   ctrl
);

	step_t  step_q;
	ucode_t cw;
	logic   jump;

	assign cw = ucode(step_q);

	always_comb begin
		unique case (cw.cond)
			C_NEVER:     jump = 1'b0;
			C_ALWAYS:    jump = 1'b1;
			C_NOT_START: jump = status.not_start;
			C_I_END:     jump = status.i_end;
			C_NOT_PEAK:  jump = status.not_peak;
			C_LW_MORE:   jump = status.lw_more;
			C_J1_EQ_I:   jump = status.j1_eq_i;
			C_J_END:     jump = status.j_end;
			C_RW_MORE:   jump = status.rw_more;
			C_PUSH_WAIT: jump = status.push_wait;
			C_OUT_BUSY:  jump = status.out_busy;
			C_CAP:       jump = status.cap;
			default:     jump = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else if (jump) begin
			step_q <= cw.target;
		end else begin
			step_q <= STEP_W'(step_q + 1'b1);
		end
	end

	assign ctrl = '{addr_sel: cw.addr_sel, op: cw.op, jump: jump};

endmodule

@@ design/ppe_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppe_dp: sample stores, scan registers and output word register
// Executes one micro-op per cycle and reports jump flags to the sequencer.
// ----------------------------------------------------------------------------
module ppe_dp
	import ppe_pkg::*;
#(
	parameter int MAX_SAMPLES = PPE_MAX_SAMPLES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ctrl_t                      ctrl,
	output status_t                    status,
	input  logic                       cfg_write,
	input  logic signed [SAMPLE_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample_value,
	input  logic signed [SAMPLE_W-1:0] sample_position,
	input  logic                       is_last,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [IDX_W-1:0]           peak_index,
	output logic signed [SAMPLE_W-1:0] peak_height,
	output logic signed [SAMPLE_W-1:0] peak_position,
	output logic [SAMPLE_W-1:0]        prominence,
	output logic                       found,
	output logic                       last_result
);

	localparam int AW = $clog2(MAX_SAMPLES);
	localparam int CW = $clog2(MAX_SAMPLES + 1);

	logic signed [SAMPLE_W-1:0] thr_q;
	logic [CW-1:0]              cnt_q, n_q, i_q, j_q;
	logic signed [SAMPLE_W-1:0] a_q, b_q, pos_q, lmin_q, rmin_q, ref_q;

	logic                       pend_v_q;
	logic [RES_CNT_W-1:0]       pcnt_q;
	logic [IDX_W-1:0]           pend_idx_q;
	logic signed [SAMPLE_W-1:0] pend_h_q, pend_pos_q;
	logic [SAMPLE_W-1:0]        pend_prom_q;

	logic                       out_valid_q, out_found_q, out_last_q;
	logic [IDX_W-1:0]           out_idx_q;
	logic signed [SAMPLE_W-1:0] out_h_q, out_pos_q;
	logic [SAMPLE_W-1:0]        out_prom_q;

	logic                       in_accept, room, we, out_free, out_load;
	logic [CW-1:0]              cnt_inc, n_next, im1, ip1, jp1, jm1;
	logic [AW-1:0]              raddr;
	logic signed [SAMPLE_W-1:0] rd_s, rd_p;
	logic [CW+IDX_W-1:0]        idx_ext;
	logic [SAMPLE_W-1:0]        new_prom;

	assign in_stall  = (ctrl.op != OP_LOAD);
	assign in_accept = in_valid && !in_stall;
	assign room      = (cnt_q < CW'(MAX_SAMPLES));
	assign cnt_inc   = CW'(cnt_q + 1'b1);
	assign n_next    = room ? cnt_inc : cnt_q;
	assign we        = in_accept && room;

	assign im1 = CW'(i_q - 1'b1);
	assign ip1 = CW'(i_q + 1'b1);
	assign jp1 = CW'(j_q + 1'b1);
	assign jm1 = CW'(j_q - 1'b1);

	always_comb begin
		unique case (ctrl.addr_sel)
			A_IM1:   raddr = im1[AW-1:0];
			A_I:     raddr = i_q[AW-1:0];
			A_IP1:   raddr = ip1[AW-1:0];
			A_J:     raddr = j_q[AW-1:0];
			default: raddr = j_q[AW-1:0];
		endcase
	end

	ppe_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_SAMPLES)) u_sample_ram (
		.clk   (clk),
		.we    (we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (sample_value),
		.raddr (raddr),
		.rdata (rd_s)
	);

	ppe_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_SAMPLES)) u_position_ram (
		.clk   (clk),
		.we    (we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (sample_position),
		.raddr (raddr),
		.rdata (rd_p)
	);

	// b_q holds the candidate height for the whole peak evaluation
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = !ctrl.jump &&
		(((ctrl.op == OP_PUSH) && pend_v_q) || (ctrl.op == OP_FIN));
	assign idx_ext  = {{IDX_W{1'b0}}, i_q};
	assign new_prom = b_q - ref_q;

	always_comb begin
		status.not_start = !(in_accept && is_last);
		status.i_end     = (ip1 >= n_q);
		status.not_peak  = !((b_q > thr_q) && (b_q > a_q) && (rd_s <= b_q));
		status.lw_more   = (j_q != '0) && (rd_s < b_q);
		status.j1_eq_i   = (jp1 == i_q);
		status.j_end     = (j_q >= n_q);
		status.rw_more   = (rd_s < b_q);
		status.push_wait = pend_v_q && !out_free;
		status.out_busy  = !out_free;
		status.cap       = (pcnt_q == RES_CNT_W'(RESULT_CAP));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= THR_RESET;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			pend_v_q    <= 1'b0;
			pcnt_q      <= '0;
		end else begin
			if (cfg_write) begin
				thr_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (ctrl.op)
				OP_LOAD: begin
					if (in_accept) begin
						if (is_last) begin
							cnt_q <= '0;
						end else if (room) begin
							cnt_q <= cnt_inc;
						end
					end
				end
				OP_PUSH: begin
					if (!ctrl.jump) begin
						pend_v_q <= 1'b1;
						pcnt_q   <= RES_CNT_W'(pcnt_q + 1'b1);
					end
				end
				OP_FIN: begin
					if (!ctrl.jump) begin
						pend_v_q <= 1'b0;
						pcnt_q   <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			OP_LOAD: begin
				if (in_accept && is_last) begin
					n_q <= n_next;
					i_q <= CW'(1);
				end
			end
			OP_LATCH_A: a_q <= rd_s;
			OP_LATCH_B: begin
				b_q   <= rd_s;
				pos_q <= rd_p;
			end
			OP_JINIT_L: j_q <= im1;
			OP_LWALK: begin
				if (ctrl.jump) begin
					j_q <= jm1;
				end else begin
					lmin_q <= rd_s;
				end
			end
			OP_JINC: j_q <= jp1;
			OP_LMIN: begin
				if (rd_s < lmin_q) begin
					lmin_q <= rd_s;
				end
			end
			OP_RINIT: begin
				rmin_q <= b_q;
				j_q    <= ip1;
			end
			OP_RSTEP: begin
				if (rd_s < rmin_q) begin
					rmin_q <= rd_s;
				end
				j_q <= jp1;
			end
			OP_REF: ref_q <= (lmin_q > rmin_q) ? lmin_q : rmin_q;
			OP_PUSH: begin
				if (!ctrl.jump) begin
					// previous peak goes out, the new one waits for its last flag
					if (pend_v_q) begin
						out_idx_q   <= pend_idx_q;
						out_h_q     <= pend_h_q;
						out_pos_q   <= pend_pos_q;
						out_prom_q  <= pend_prom_q;
						out_found_q <= 1'b1;
						out_last_q  <= 1'b0;
					end
					pend_idx_q  <= idx_ext[IDX_W-1:0];
					pend_h_q    <= b_q;
					pend_pos_q  <= pos_q;
					pend_prom_q <= new_prom;
				end
			end
			OP_NEXT: i_q <= ip1;
			OP_FIN: begin
				if (!ctrl.jump) begin
					out_last_q <= 1'b1;
					if (pend_v_q) begin
						out_idx_q   <= pend_idx_q;
						out_h_q     <= pend_h_q;
						out_pos_q   <= pend_pos_q;
						out_prom_q  <= pend_prom_q;
						out_found_q <= 1'b1;
					end else begin
						out_idx_q   <= '0;
						out_h_q     <= '0;
						out_pos_q   <= '0;
						out_prom_q  <= '0;
						out_found_q <= 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

	assign out_valid     = out_valid_q;
	assign peak_index    = out_idx_q;
	assign peak_height   = out_h_q;
	assign peak_position = out_pos_q;
	assign prominence    = out_prom_q;
	assign found         = out_found_q;
	assign last_result   = out_last_q;

endmodule

@@ design/peak_prominence_engine_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peak_prominence_engine_core: topographic peak prominence over a sample set
// Samples load one word per cycle; the word marked last starts a microcoded
// scan that emits one word per peak in index order, up to RESULT_CAP peaks,
// or one empty word. Scan: each interior sample is tested; per peak the left
// side is walked, its minimum found, the right side walked, and the result
// pushed; a final step closes the set. All reads share the single read port
// of the sample store.
// Reset: threshold to the most negative value, store empty, no word pending.
// ----------------------------------------------------------------------------
module peak_prominence_engine_core
	import ppe_pkg::*;
#(
	parameter int MAX_SAMPLES = PPE_MAX_SAMPLES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic signed [SAMPLE_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample_value,
	input  logic signed [SAMPLE_W-1:0] sample_position,
	input  logic                       is_last,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [IDX_W-1:0]           peak_index,
	output logic signed [SAMPLE_W-1:0] peak_height,
	output logic signed [SAMPLE_W-1:0] peak_position,
	output logic [SAMPLE_W-1:0]        prominence,
	output logic                       found,
	output logic                       last_result
);

	ctrl_t   ctrl;
	status_t status;

	ppe_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	ppe_dp #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctrl            (ctrl),
		.status          (status),
		.cfg_write       (cfg_write),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.sample_value    (sample_value),
		.sample_position (sample_position),
		.is_last         (is_last),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.peak_index      (peak_index),
		.peak_height     (peak_height),
		.peak_position   (peak_position),
		.prominence      (prominence),
		.found           (found),
		.last_result     (last_result)
	);

	// the last word of a set closes the input until the scan is done
	a_scan_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && is_last |=> in_stall)
		else $error("input still open after last word");

	// the closing step always leaves a final word in the output register
	a_fin_word: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.op == OP_FIN && !ctrl.jump |=> out_valid && last_result)
		else $error("final word missing after scan");

	// an empty result is always the last word of its set
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> last_result && prominence == '0)
		else $error("empty result not marked last");

endmodule

@@ dv/peak_prominence_engine_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peak_prominence_engine_core_tb: self-checking bench for the prominence core
// Loads sample sets of many shapes and sizes under five threshold settings
// and three stall mixes. A scoreboard predicts each set's peak words and
// compares every result word field by field, in order.
// ----------------------------------------------------------------------------
module peak_prominence_engine_core_tb;
	import ppe_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int DRAIN_TAIL  = 16;
	localparam int PHASE_WORDS = 32;
	localparam logic signed [SAMPLE_W-1:0] S_MIN = THR_RESET;
	localparam logic signed [SAMPLE_W-1:0] S_MAX = ~THR_RESET;

	typedef enum int {SH_NOISE, SH_BUMPY, SH_SAW, SH_EXTREME} shape_t;

	typedef struct packed {
		logic [IDX_W-1:0]           peak_idx;
		logic signed [SAMPLE_W-1:0] height;
		logic signed [SAMPLE_W-1:0] pos;
		logic [SAMPLE_W-1:0]        prom;
		logic                       found;
		logic                       last_flag;
	} peak_t;

	class peak_scoreboard;
		logic signed [SAMPLE_W-1:0] threshold;
		logic signed [SAMPLE_W-1:0] heights [PPE_MAX_SAMPLES];
		logic signed [SAMPLE_W-1:0] positions [PPE_MAX_SAMPLES];
		int unsigned fill;
		peak_t expected_peaks[$];
		int errors;
		int checked;
		int peaks_checked;

		function new();
			threshold = THR_RESET;
			fill = 0;
			errors = 0;
			checked = 0;
			peaks_checked = 0;
		endfunction

		function int pending();
			return expected_peaks.size();
		endfunction

		// height minus the higher of the two side minima
		function logic [SAMPLE_W-1:0] prominence_of(int unsigned p, int unsigned n);
			logic signed [SAMPLE_W-1:0] h, lmin, rmin, floor_lvl;
			int unsigned j;
			h = heights[p];
			j = p - 1;
			while (j > 0 && heights[j] < h)
				j--;
			lmin = heights[j];
			while (j < p) begin
				if (heights[j] < lmin)
					lmin = heights[j];
				j++;
			end
			rmin = h;
			j = p + 1;
			while (j < n && heights[j] < h) begin
				if (heights[j] < rmin)
					rmin = heights[j];
				j++;
			end
			floor_lvl = (lmin > rmin) ? lmin : rmin;
			return h - floor_lvl;
		endfunction

		function void note_word(logic signed [SAMPLE_W-1:0] value,
				logic signed [SAMPLE_W-1:0] position, logic is_end);
			peak_t set_peaks[$];
			peak_t r;
			int unsigned n, i;
			// words past a full store are dropped, but a dropped last still scans
			if (fill < PPE_MAX_SAMPLES) begin
				heights[fill] = value;
				positions[fill] = position;
				fill++;
			end
			if (!is_end)
				return;
			n = fill;
			fill = 0;
			for (i = 1; i + 1 < n && set_peaks.size() < RESULT_CAP; i++) begin
				if (heights[i] > threshold && heights[i] > heights[i-1] &&
						heights[i+1] <= heights[i]) begin
					r.peak_idx = IDX_W'(i);
					r.height = heights[i];
					r.pos = positions[i];
					r.prom = prominence_of(i, n);
					r.found = 1'b1;
					r.last_flag = 1'b0;
					set_peaks = {set_peaks, r};
				end
			end
			if (set_peaks.size() == 0) begin
				r = '0;
				r.last_flag = 1'b1;
				set_peaks = {set_peaks, r};
			end else begin
				set_peaks[set_peaks.size()-1].last_flag = 1'b1;
			end
			expected_peaks = {expected_peaks, set_peaks};
		endfunction

		function void check_field(string name, logic [SAMPLE_W-1:0] want,
				logic [SAMPLE_W-1:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected 0x%08h, actual 0x%08h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(peak_t got);
			peak_t want;
			if (expected_peaks.size() == 0) begin
				$error("result word with nothing expected: peak_index %0d", got.peak_idx);
				errors++;
				return;
			end
			want = expected_peaks.pop_front();
			checked++;
			if (want.found)
				peaks_checked++;
			check_field("peak_index", SAMPLE_W'(want.peak_idx), SAMPLE_W'(got.peak_idx));
			check_field("peak_height", want.height, got.height);
			check_field("peak_position", want.pos, got.pos);
			check_field("prominence", want.prom, got.prom);
			check_field("found", SAMPLE_W'(want.found), SAMPLE_W'(got.found));
			check_field("last_result", SAMPLE_W'(want.last_flag), SAMPLE_W'(got.last_flag));
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_write = 1'b0;
	logic signed [SAMPLE_W-1:0] cfg_data = '0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] sample_value = '0;
	logic signed [SAMPLE_W-1:0] sample_position = '0;
	logic                       is_last = 1'b0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic [IDX_W-1:0]           peak_index;
	logic signed [SAMPLE_W-1:0] peak_height;
	logic signed [SAMPLE_W-1:0] peak_position;
	logic [SAMPLE_W-1:0]        prominence;
	logic                       found;
	logic                       last_result;

	peak_scoreboard sb;
	int src_idle = 0;
	int dst_idle = 0;
	int words_sent = 0;
	int sets_sent = 0;
	int cycle_count = 0;

	peak_prominence_engine_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.sample_value   (sample_value),
		.sample_position(sample_position),
		.is_last        (is_last),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.peak_index     (peak_index),
		.peak_height    (peak_height),
		.peak_position  (peak_position),
		.prominence     (prominence),
		.found          (found),
		.last_result    (last_result)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < dst_idle);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// both handshakes sampled at the edge, before any new drive lands
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_word(sample_value, sample_position, is_last);
			if (out_valid && !out_stall)
				sb.check_result('{peak_idx: peak_index, height: peak_height,
					pos: peak_position, prom: prominence, found: found,
					last_flag: last_result});
		end
	end

	task automatic send_word(input logic signed [SAMPLE_W-1:0] value,
			input logic signed [SAMPLE_W-1:0] position, input logic is_end);
		if ($urandom_range(0, 99) < src_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < src_idle);
		end
		in_valid <= 1'b1;
		sample_value <= value;
		sample_position <= position;
		is_last <= is_end;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic send_set(input int len, input shape_t shape,
			input logic signed [SAMPLE_W-1:0] base);
		logic signed [SAMPLE_W-1:0] h;
		int k;
		for (k = 0; k < len; k++) begin
			case (shape)
				SH_NOISE: h = $urandom;
				SH_BUMPY: h = base + $urandom_range(0, 6);
				SH_SAW: h = (k % 2) ? base + 1 + $urandom_range(0, 3) : base;
				default: begin
					case ($urandom_range(0, 5))
						0: h = S_MIN;
						1: h = S_MAX;
						2: h = S_MIN + 1;
						3: h = S_MAX - 1;
						4: h = 0;
						default: h = -1;
					endcase
				end
			endcase
			send_word(h, $urandom, k == len - 1);
		end
		sets_sent++;
	endtask

	// drop valid and let every expected word come out, plus the scan tail
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	task automatic write_threshold(input logic signed [SAMPLE_W-1:0] value);
		cfg_write <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		sb.threshold = value;
		@(posedge clk);
	endtask

	task automatic run_phase(input int src_pct, input int dst_pct,
			input logic signed [SAMPLE_W-1:0] thr);
		int start, len;
		shape_t shape;
		logic signed [SAMPLE_W-1:0] base;
		src_idle = src_pct;
		dst_idle = dst_pct;
		write_threshold(thr);
		start = words_sent;
		while (words_sent - start < PHASE_WORDS) begin
			// short sets here; the full store gets its own set at the end
			len = $urandom_range(1, 20);
			shape = shape_t'($urandom_range(0, 3));
			base = $urandom_range(0, 1) ? sb.threshold - 3 : $signed($urandom);
			send_set(len, shape, base);
		end
		wait_idle();
	endtask

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed sets at the reset threshold
		src_idle = 19;
		dst_idle = 85;
		send_word(32'sd5, 32'sd0, 1'b1);
		send_word(32'sd1, 32'sd1, 1'b0);
		send_word(32'sd9, 32'sd2, 1'b1);
		send_word(S_MIN, S_MIN, 1'b0);
		send_word(S_MAX, S_MAX, 1'b0);
		send_word(S_MIN, 32'sd0, 1'b1);
		// plateau: peak on the first of two equal samples, zero prominence
		send_word(32'sd0, 32'sd10, 1'b0);
		send_word(32'sd5, 32'sd11, 1'b0);
		send_word(32'sd5, 32'sd12, 1'b0);
		send_word(32'sd0, 32'sd13, 1'b1);
		// two equal peaks bounding each other
		send_word(32'sd3, -32'sd1, 1'b0);
		send_word(32'sd9, -32'sd2, 1'b0);
		send_word(32'sd2, -32'sd3, 1'b0);
		send_word(32'sd9, -32'sd4, 1'b0);
		send_word(32'sd1, -32'sd5, 1'b1);
		wait_idle();
		// a peak equal to the threshold is not a peak
		write_threshold(32'sd9);
		send_word(32'sd0, 32'sd20, 1'b0);
		send_word(32'sd9, 32'sd21, 1'b0);
		send_word(32'sd0, 32'sd22, 1'b0);
		send_word(32'sd10, 32'sd23, 1'b0);
		send_word(32'sd0, 32'sd24, 1'b1);
		wait_idle();
		write_threshold(S_MAX);
		send_word(32'sd0, 32'sd30, 1'b0);
		send_word(32'sd7, 32'sd31, 1'b0);
		send_word(32'sd0, 32'sd32, 1'b1);
		wait_idle();

		run_phase(19, 85, 32'sd0);
		run_phase(85, 19, $signed($urandom));
		run_phase(0, 0, S_MIN);
		// full store with the last word dropped, densest peak pattern
		send_set(PPE_MAX_SAMPLES + 3, SH_SAW, 32'sd0);
		wait_idle();

		if (sb.pending() != 0) begin
			$error("%0d expected result words never arrived", sb.pending());
			sb.errors++;
		end
		$display("Ran %0d sample sets (%0d words), five thresholds, three stall mixes.",
			sets_sent, words_sent);
		$display("Checked %0d result words, %0d of them peaks.", sb.checked, sb.peaks_checked);
		if (sb.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

@@ sim.f @@
design/ppe_pkg.sv
design/ppe_ram.sv
design/ppe_seq.sv
design/ppe_dp.sv
design/peak_prominence_engine_core.sv
dv/peak_prominence_engine_core_tb.sv
